// File: design/vbf_pkg.sv
// vbf_pkg: shared types, constants and fixed-point helpers for the voice band filter chain
// no dependencies; imported by the interfaces, the cells and the top level
package vbf_pkg;

   localparam int STAGES_DEF    = 4;
   localparam int FRAC_BITS_DEF = 20;
   localparam int COEF_BITS     = 20;
   localparam int STATE_W       = 32;
   localparam int SAMPLE_W      = 16;
   localparam int ALPHA_W       = 21;
   localparam int TAP_W         = 24;
   localparam int CSR_DATA_W    = 24;
   localparam int CSR_INDEX_W   = 4;
   localparam int ENABLE_W      = 3;
   localparam int NUM_REGS      = 8;

   typedef logic signed [STATE_W-1:0]  state_type;
   typedef logic signed [TAP_W-1:0]    tap_type;
   typedef logic        [ALPHA_W-1:0]  alpha_type;
   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      logic      valid;
      state_type x;
   } tok_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_ENABLES  = 4'd0,
      REG_HP_ALPHA = 4'd1,
      REG_LP_ALPHA = 4'd2,
      REG_PEAK_B0  = 4'd3,
      REG_PEAK_B1  = 4'd4,
      REG_PEAK_B2  = 4'd5,
      REG_PEAK_A1  = 4'd6,
      REG_PEAK_A2  = 4'd7
   } reg_index_type;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_RUN  = 4'b0010,
      S_MUL  = 4'b0100,
      S_OUT  = 4'b1000
   } ctrl_state_type;

   localparam int EN_HP   = 0;
   localparam int EN_LP   = 1;
   localparam int EN_PEAK = 2;

   localparam logic signed [63:0] ROUND_HALF = 64'sd1 <<< (COEF_BITS - 1);
   localparam logic signed [63:0] STATE_MAX  = 64'sd2147483647;
   localparam logic signed [63:0] STATE_MIN  = -64'sd2147483648;

   // round to nearest, ties up
   function automatic logic signed [63:0] round_q(input logic signed [63:0] p);
      round_q = (p + ROUND_HALF) >>> COEF_BITS;
   endfunction

   function automatic state_type sat32(input logic signed [63:0] v);
      if (v > STATE_MAX) begin
         sat32 = STATE_MAX[STATE_W-1:0];
      end else if (v < STATE_MIN) begin
         sat32 = STATE_MIN[STATE_W-1:0];
      end else begin
         sat32 = v[STATE_W-1:0];
      end
   endfunction

endpackage

// File: design/vbf_stream_if.sv
// vbf_req_if / vbf_rsp_if: valid-ready channels for sample beats in and out
// depends on vbf_pkg
interface vbf_req_if;
   import vbf_pkg::*;
   logic       valid;
   logic       ready;
   sample_type sample_in;
   logic       chunk_end;
   modport source (output valid, output sample_in, output chunk_end, input ready);
   modport sink   (input valid, input sample_in, input chunk_end, output ready);
endinterface

interface vbf_rsp_if;
   import vbf_pkg::*;
   logic       valid;
   logic       ready;
   sample_type sample_out;
   logic       chunk_end_out;
   modport source (output valid, output sample_out, output chunk_end_out, input ready);
   modport sink   (input valid, input sample_out, input chunk_end_out, output ready);
endinterface

// File: design/voice_band_filter_chain.sv
// voice_band_filter_chain: one sample beat in, one filtered sample beat out.
// The biquad shares one multiplier over its five taps. With all filters off the result is
// offered in the cycle after the beat is taken; one sample is in flight at a time and the
// next beat is taken after the result is taken.
// Depends on vbf_pkg, vbf_stream_if, vbf_pole_cell and vbf_peak_cell.
module voice_band_filter_chain #(
   parameter int STAGES    = vbf_pkg::STAGES_DEF,
   parameter int FRAC_BITS = vbf_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   vbf_req_if.sink                            req_chan,
   vbf_rsp_if.source                          rsp_chan,
   input  logic                               csr_we,
   input  logic [vbf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [vbf_pkg::CSR_DATA_W-1:0]     csr_data
);
   import vbf_pkg::*;

   localparam logic signed [STATE_W-1:0] ONE     = STATE_W'(64'sd1 <<< FRAC_BITS);
   localparam logic signed [47:0]        FULL    = 48'sd32767;
   localparam sample_type                NEG_LIM = -16'sd32767;

   logic [ENABLE_W-1:0] en_ff;
   alpha_type           hp_alpha_ff, lp_alpha_ff;
   tap_type             b0_ff, b1_ff, b2_ff, a1_ff, a2_ff;
   logic                clear;

   ctrl_state_type state_ff;
   logic           accept;
   logic           chunk_ff;
   sample_type     sample_ff;
   logic signed [47:0] p_ff;
   state_type      xc;
   tok_type        tok [2*STAGES+1];
   tok_type        tok_last;
   tok_type        tok0_ff;

   assign clear = csr_we && (csr_index < CSR_INDEX_W'(NUM_REGS));

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff       <= '0;
         hp_alpha_ff <= '0;
         lp_alpha_ff <= '0;
         b0_ff       <= TAP_W'(24'sd1048576);
         b1_ff       <= '0;
         b2_ff       <= '0;
         a1_ff       <= '0;
         a2_ff       <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_ENABLES:  en_ff       <= csr_data[ENABLE_W-1:0];
            REG_HP_ALPHA: hp_alpha_ff <= csr_data[ALPHA_W-1:0];
            REG_LP_ALPHA: lp_alpha_ff <= csr_data[ALPHA_W-1:0];
            REG_PEAK_B0:  b0_ff       <= csr_data[TAP_W-1:0];
            REG_PEAK_B1:  b1_ff       <= csr_data[TAP_W-1:0];
            REG_PEAK_B2:  b2_ff       <= csr_data[TAP_W-1:0];
            REG_PEAK_A1:  a1_ff       <= csr_data[TAP_W-1:0];
            REG_PEAK_A2:  a2_ff       <= csr_data[TAP_W-1:0];
            default: ;
         endcase
      end
   end

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);

   assign tok[0] = tok0_ff;

   genvar k;
   generate
      for (k = 0; k < 2*STAGES; k++) begin : g_cell
         vbf_pole_cell #(.HIGHPASS(k < STAGES)) u_cell (
            .clock   (clock),
            .reset   (reset),
            .clear   (clear),
            .enable  ((k < STAGES) ? en_ff[EN_HP] : en_ff[EN_LP]),
            .alpha   ((k < STAGES) ? hp_alpha_ff : lp_alpha_ff),
            .tok_in  (tok[k]),
            .tok_out (tok[k+1])
         );
      end
   endgenerate

   vbf_peak_cell u_peak (
      .clock   (clock),
      .reset   (reset),
      .clear   (clear),
      .enable  (en_ff[EN_PEAK]),
      .b0      (b0_ff),
      .b1      (b1_ff),
      .b2      (b2_ff),
      .a1      (a1_ff),
      .a2      (a2_ff),
      .tok_in  (tok[2*STAGES]),
      .tok_out (tok_last)
   );

   always_comb begin
      if (tok_last.x > ONE) begin
         xc = ONE;
      end else if (tok_last.x < -ONE) begin
         xc = -ONE;
      end else begin
         xc = tok_last.x;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         tok0_ff.valid <= 1'b0;
      end else begin
         tok0_ff.valid <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (en_ff == '0) begin
                     state_ff <= S_OUT;
                  end else begin
                     state_ff      <= S_RUN;
                     tok0_ff.valid <= 1'b1;
                  end
               end
            end
            S_RUN: begin
               if (tok_last.valid) begin
                  state_ff <= S_MUL;
               end
            end
            S_MUL: state_ff <= S_OUT;
            S_OUT: begin
               if (rsp_chan.ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         chunk_ff  <= req_chan.chunk_end;
         tok0_ff.x <= STATE_W'(req_chan.sample_in) <<< (FRAC_BITS - 15);
         sample_ff <= (req_chan.sample_in < NEG_LIM) ? NEG_LIM : req_chan.sample_in;
      end else if (state_ff == S_MUL) begin
         if (p_ff >= 0) begin
            sample_ff <= SAMPLE_W'(p_ff >>> FRAC_BITS);
         end else begin
            sample_ff <= SAMPLE_W'(-((-p_ff) >>> FRAC_BITS));
         end
      end
      if (tok_last.valid) begin
         p_ff <= 48'(xc) * FULL;
      end
   end

   assign rsp_chan.valid         = (state_ff == S_OUT);
   assign rsp_chan.sample_out    = sample_ff;
   assign rsp_chan.chunk_end_out = chunk_ff;

   assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("control state not one-hot");
   assert property (@(posedge clock) disable iff (reset)
                    tok_last.valid |-> state_ff == S_RUN)
      else $error("chain result outside run");
   assert property (@(posedge clock) disable iff (reset)
                    (accept && en_ff == '0) |=> rsp_chan.valid)
      else $error("bypass result missing");
   assert property (@(posedge clock) disable iff (reset)
                    rsp_chan.valid |-> rsp_chan.sample_out != 16'h8000)
      else $error("output below negative full scale");

endmodule

// File: design/vbf_pole_cell.sv
// vbf_pole_cell: one one-pole stage (high-pass or low-pass) holding its own history
// depends on vbf_pkg; chained by voice_band_filter_chain
module vbf_pole_cell #(
   parameter bit HIGHPASS = 1'b1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              clear,
   input  logic              enable,
   input  vbf_pkg::alpha_type alpha,
   input  vbf_pkg::tok_type  tok_in,
   output vbf_pkg::tok_type  tok_out
);
   import vbf_pkg::*;

   state_type yprev_ff;
   state_type y_in;
   tok_type   tok_ff;
   logic signed [63:0] alpha_ext;
   logic               take;

   assign alpha_ext = $signed({43'd0, alpha});
   assign take      = tok_in.valid && enable;

   generate
      if (HIGHPASS) begin : g_hp
         state_type          xprev_ff;
         logic signed [63:0] d;
         logic signed [63:0] prod;
         assign d    = 64'(yprev_ff) + 64'(tok_in.x) - 64'(xprev_ff);
         assign prod = d * alpha_ext;
         assign y_in = sat32(round_q(prod));
         always_ff @(posedge clock) begin
            if (reset || clear) begin
               xprev_ff <= '0;
            end else if (take) begin
               xprev_ff <= tok_in.x;
            end
         end
      end else begin : g_lp
         logic signed [63:0] d;
         logic signed [63:0] prod;
         assign d    = 64'(tok_in.x) - 64'(yprev_ff);
         assign prod = d * alpha_ext;
         assign y_in = sat32(64'(yprev_ff) + round_q(prod));
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         yprev_ff <= '0;
      end else if (take) begin
         yprev_ff <= y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in.valid;
      end
      tok_ff.x <= enable ? y_in : tok_in.x;
   end

   assign tok_out = tok_ff;

endmodule

// File: design/vbf_peak_cell.sv
// vbf_peak_cell: peaking biquad, five taps through one shared multiplier
// depends on vbf_pkg; last cell of the chain in voice_band_filter_chain
module vbf_peak_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             clear,
   input  logic             enable,
   input  vbf_pkg::tap_type b0,
   input  vbf_pkg::tap_type b1,
   input  vbf_pkg::tap_type b2,
   input  vbf_pkg::tap_type a1,
   input  vbf_pkg::tap_type a2,
   input  vbf_pkg::tok_type tok_in,
   output vbf_pkg::tok_type tok_out
);
   import vbf_pkg::*;

   localparam logic [2:0] PH_LAST = 3'd5;

   state_type          x1_ff, x2_ff, y1_ff, y2_ff, xin_ff;
   logic               run_ff;
   logic [2:0]         ph_ff;
   logic signed [63:0] prod_ff;
   logic               sub_ff;
   logic signed [63:0] acc_ff;
   logic signed [63:0] acc_in;
   tap_type            coef;
   state_type          oper;
   state_type          y_in;
   tok_type            tok_ff;

   always_comb begin
      case (ph_ff)
         3'd0: begin coef = b0; oper = xin_ff; end
         3'd1: begin coef = b1; oper = x1_ff;  end
         3'd2: begin coef = b2; oper = x2_ff;  end
         3'd3: begin coef = a1; oper = y1_ff;  end
         3'd4: begin coef = a2; oper = y2_ff;  end
         default: begin coef = '0; oper = '0; end
      endcase
   end

   assign acc_in = sub_ff ? (acc_ff - prod_ff) : (acc_ff + prod_ff);
   assign y_in   = sat32(round_q(acc_in));

   always_ff @(posedge clock) begin
      prod_ff <= 64'(coef) * 64'(oper);
      sub_ff  <= (ph_ff >= 3'd3);
      if (reset) begin
         run_ff       <= 1'b0;
         ph_ff        <= '0;
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= 1'b0;
         if (tok_in.valid) begin
            if (enable) begin
               run_ff <= 1'b1;
               ph_ff  <= '0;
               xin_ff <= tok_in.x;
               acc_ff <= '0;
            end else begin
               tok_ff.valid <= 1'b1;
               tok_ff.x     <= tok_in.x;
            end
         end else if (run_ff) begin
            ph_ff <= ph_ff + 3'd1;
            if (ph_ff != 3'd0) begin
               acc_ff <= acc_in;
            end
            if (ph_ff == PH_LAST) begin
               run_ff       <= 1'b0;
               tok_ff.valid <= 1'b1;
               tok_ff.x     <= y_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         x1_ff <= '0;
         x2_ff <= '0;
         y1_ff <= '0;
         y2_ff <= '0;
      end else if (run_ff && ph_ff == PH_LAST) begin
         x2_ff <= x1_ff;
         x1_ff <= xin_ff;
         y2_ff <= y1_ff;
         y1_ff <= y_in;
      end
   end

   assign tok_out = tok_ff;

   assert property (@(posedge clock) disable iff (reset) tok_in.valid |-> !run_ff)
      else $error("biquad started while busy");
   assert property (@(posedge clock) disable iff (reset) run_ff |-> ph_ff <= PH_LAST)
      else $error("biquad phase out of range");
   assert property (@(posedge clock) disable iff (reset)
                    (run_ff && ph_ff == PH_LAST) |=> tok_out.valid)
      else $error("biquad result missing");

endmodule

// File: tb/voice_band_filter_chain_tb.sv
// voice_band_filter_chain_tb: self-checking bench for the voice band filter chain
// drives random and directed sample beats, predicts each result in fixed point and compares
// depends on vbf_pkg, vbf_stream_if (vbf_req_if, vbf_rsp_if) and voice_band_filter_chain
module voice_band_filter_chain_tb;
   import vbf_pkg::*;

   localparam int NSTAGE = 4;
   localparam int QBITS = 20;
   localparam int IDLE_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 40;
   localparam int LONG_HOLD = 300;
   localparam logic [CSR_INDEX_W-1:0] SPARE_INDEX_FIRST = 4'd8;
   localparam logic [CSR_INDEX_W-1:0] SPARE_INDEX_LAST = 4'd15;
   localparam longint UNITY = 64'sd1 <<< QBITS;

   typedef struct {
      logic signed [15:0] smp;
      logic ce;
   } out_beat_t;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   vbf_req_if req ();
   vbf_rsp_if rsp ();

   voice_band_filter_chain uut (
      .clock(clock), .reset(reset), .req_chan(req), .rsp_chan(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   // predictor copy of registers and filter state
   logic [2:0] enables;
   longint hp_gain, lp_gain, tap_b0, tap_b1, tap_b2, tap_a1, tap_a2;
   int hp_in [NSTAGE];
   int hp_out [NSTAGE];
   int lp_out [NSTAGE];
   int pk_x1, pk_x2, pk_y1, pk_y2;

   out_beat_t pending_beats [$];
   int errors = 0;
   int hold_request = 0;
   bit no_idle = 0;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic int clamp_state(input longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
   endfunction

   function automatic longint round_q20(input longint p);
      return (p + (64'sd1 <<< (QBITS - 1))) >>> QBITS;
   endfunction

   function automatic void clear_filters();
      for (int k = 0; k < NSTAGE; k++) begin
         hp_in[k] = 0;
         hp_out[k] = 0;
         lp_out[k] = 0;
      end
      pk_x1 = 0;
      pk_x2 = 0;
      pk_y1 = 0;
      pk_y2 = 0;
   endfunction

   function automatic out_beat_t filter_sample(input logic signed [15:0] s, input logic ce);
      longint x, d, acc, p;
      int y;
      out_beat_t r;
      r.ce = ce;
      if (enables == 3'd0) begin
         r.smp = (s == -16'sd32768) ? -16'sd32767 : s;
         return r;
      end
      x = longint'(s) * 32;
      if (enables[EN_HP]) begin
         for (int k = 0; k < NSTAGE; k++) begin
            d = longint'(hp_out[k]) + x - longint'(hp_in[k]);
            y = clamp_state(round_q20(d * hp_gain));
            hp_in[k] = int'(x);
            hp_out[k] = y;
            x = y;
         end
      end
      if (enables[EN_LP]) begin
         for (int k = 0; k < NSTAGE; k++) begin
            d = x - longint'(lp_out[k]);
            lp_out[k] = clamp_state(longint'(lp_out[k]) + round_q20(d * lp_gain));
            x = lp_out[k];
         end
      end
      if (enables[EN_PEAK]) begin
         acc = tap_b0 * x + tap_b1 * pk_x1 + tap_b2 * pk_x2 - tap_a1 * pk_y1 - tap_a2 * pk_y2;
         y = clamp_state(round_q20(acc));
         pk_x2 = pk_x1;
         pk_x1 = int'(x);
         pk_y2 = pk_y1;
         pk_y1 = y;
         x = y;
      end
      if (x > UNITY) x = UNITY;
      if (x < -UNITY) x = -UNITY;
      p = x * 32767;
      if (p >= 0) x = p >>> QBITS;
      else x = -((-p) >>> QBITS);
      r.smp = x[15:0];
      return r;
   endfunction

   // one register write, block idle
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_ENABLES: enables = v[2:0];
         REG_HP_ALPHA: hp_gain = longint'(v[20:0]);
         REG_LP_ALPHA: lp_gain = longint'(v[20:0]);
         REG_PEAK_B0: tap_b0 = longint'($signed(v));
         REG_PEAK_B1: tap_b1 = longint'($signed(v));
         REG_PEAK_B2: tap_b2 = longint'($signed(v));
         REG_PEAK_A1: tap_a1 = longint'($signed(v));
         REG_PEAK_A2: tap_a2 = longint'($signed(v));
         default: return;
      endcase
      clear_filters();
   endtask

   task automatic send_sample(input logic signed [15:0] s, input logic ce);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.sample_in <= s;
      req.chunk_end <= ce;
      do @(posedge clock); while (!req.ready);
      pending_beats.push_back(filter_sample(s, ce));
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [15:0] rand_sample();
      case ($urandom_range(0, 9))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2, 3, 4: return 16'($signed($urandom_range(0, 1000)) - 500);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] rand_alpha();
      case ($urandom_range(0, 5))
         0: return 24'd0;
         1: return 24'd1048576;
         2: return 24'h1fffff;
         default: return 24'($urandom_range(0, 1048576));
      endcase
   endfunction

   task automatic test_passthrough();
      write_reg(REG_ENABLES, 24'd0);
      send_sample(16'sh7fff, 1'b0);
      send_sample(16'sh8000, 1'b1);
      send_sample(16'sh8001, 1'b0);
      send_sample(16'sh0000, 1'b1);
      send_sample(-16'sd1, 1'b0);
      drain();
   endtask

   task automatic test_sections();
      write_reg(REG_HP_ALPHA, 24'h1fffff);
      write_reg(REG_ENABLES, 24'd1);
      send_sample(16'sh7fff, 1'b0);
      send_sample(16'sh8000, 1'b1);
      send_sample(16'sh7fff, 1'b0);
      drain();
      write_reg(REG_LP_ALPHA, 24'd1048576);
      write_reg(REG_ENABLES, 24'd2);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7fff, 1'b1);
      drain();
      write_reg(REG_LP_ALPHA, 24'd0);
      send_sample(16'sh7fff, 1'b0);
      drain();
      // biquad feedback runs away into the saturation limits
      write_reg(REG_PEAK_B0, 24'h7fffff);
      write_reg(REG_PEAK_A1, 24'h800000);
      write_reg(REG_PEAK_A2, 24'h7fffff);
      write_reg(REG_PEAK_B1, 24'h800000);
      write_reg(REG_PEAK_B2, 24'h7fffff);
      write_reg(REG_ENABLES, 24'd4);
      repeat (6) send_sample(16'sh7fff, 1'b0);
      drain();
      // unused indexes leave state alone
      write_reg(SPARE_INDEX_FIRST, 24'hffffff);
      write_reg(SPARE_INDEX_LAST, 24'h000000);
      send_sample(16'sh8000, 1'b1);
      drain();
   endtask

   task automatic test_random(input int phases);
      logic [2:0] en;
      for (int ph = 0; ph < phases; ph++) begin
         no_idle = (ph % 5 == 3);
         write_reg(REG_HP_ALPHA, rand_alpha());
         write_reg(REG_LP_ALPHA, rand_alpha());
         if ($urandom_range(0, 2) == 0) begin
            write_reg(REG_PEAK_B0, 24'($urandom));
            write_reg(REG_PEAK_B1, 24'($urandom));
            write_reg(REG_PEAK_B2, 24'($urandom));
            write_reg(REG_PEAK_A1, 24'($urandom));
            write_reg(REG_PEAK_A2, 24'($urandom));
         end else begin
            // peaking shape near unity gain
            write_reg(REG_PEAK_B0, 24'(1048576 + $urandom_range(0, 400000)));
            write_reg(REG_PEAK_B1, 24'(-1800000 + $urandom_range(0, 300000)));
            write_reg(REG_PEAK_B2, 24'(700000 + $urandom_range(0, 200000)));
            write_reg(REG_PEAK_A1, 24'(-1800000 + $urandom_range(0, 300000)));
            write_reg(REG_PEAK_A2, 24'(700000 + $urandom_range(0, 200000)));
         end
         en = (ph < 8) ? 3'(ph) : 3'($urandom_range(0, 7));
         write_reg(REG_ENABLES, {21'd0, en});
         if ($urandom_range(0, 3) == 0)
            write_reg(4'($urandom_range(SPARE_INDEX_FIRST, SPARE_INDEX_LAST)), 24'($urandom));
         if (ph == 2) hold_request = LONG_HOLD;
         repeat ($urandom_range(60, 110)) send_sample(rand_sample(), ($urandom_range(0, 7) == 0));
         drain();
      end
      no_idle = 0;
   endtask

   // result side
   initial begin
      out_beat_t want;
      int stall;
      rsp.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (hold_request > 0) begin
            rsp.ready <= 1'b0;
            repeat (hold_request) @(posedge clock);
            hold_request = 0;
         end
         stall = no_idle ? 0 : $urandom_range(0, 8);
         if (stall > 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (!rsp.valid);
         if (pending_beats.size() == 0) begin
            $display("%0t: unexpected beat sample %0d chunk_end %0b", $time,
                     rsp.sample_out, rsp.chunk_end_out);
            errors++;
         end else begin
            want = pending_beats.pop_front();
            if (rsp.sample_out !== want.smp) begin
               $display("%0t: sample_out expected %0d actual %0d", $time, want.smp,
                        rsp.sample_out);
               errors++;
            end
            if (rsp.chunk_end_out !== want.ce) begin
               $display("%0t: chunk_end_out expected %0b actual %0b", $time, want.ce,
                        rsp.chunk_end_out);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles with no beat on either side
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet = 0;
         else quiet++;
      end
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req.valid = 1'b0;
      req.sample_in = '0;
      req.chunk_end = 1'b0;
      enables = 3'd0;
      hp_gain = 0;
      lp_gain = 0;
      tap_b0 = 1048576;
      tap_b1 = 0;
      tap_b2 = 0;
      tap_a1 = 0;
      tap_a2 = 0;
      clear_filters();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_passthrough();
      test_sections();
      test_random(15);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
